### rtl/core/nisq_pkg.sv
`timescale 1ns / 1ps
package nisq_pkg;

  localparam int NISQ_ROUNDS = 3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_INVALID  = 2'd2
  } status_t;

  // One word as it travels between rounds.
  typedef struct packed {
    logic        valid;
    logic        live;    // rounds still update the estimate
    status_t     status;
    logic [31:0] value;
    logic [15:0] est;
  } item_t;

  // One word inside a round, with the divider's working state.
  typedef struct packed {
    item_t       it;
    logic [31:0] sq;
    logic        neg;
    logic [15:0] wmag;
    logic [31:0] dmag;
    logic [16:0] rem;
    logic [16:0] q;
  } rnd_t;

endpackage

### rtl/core/nisq_if.sv
`timescale 1ns / 1ps
interface nisq_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] radicand;
  modport source (output valid, output radicand, input ready);
  modport sink (input valid, input radicand, output ready);
endinterface

interface nisq_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] root;
  logic [1:0]  status;
  modport source (output valid, output root, output status, input ready);
  modport sink (input valid, input root, input status, output ready);
endinterface

### rtl/core/nisq_round.sv
`timescale 1ns / 1ps
module nisq_round
  import nisq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  item_t i,
  output item_t o
);

  rnd_t s1, s2, s3, s4, s5;
  rnd_t s1_next, s2_next, s3_next, s4_next, s5_next;
  item_t s6, s6_next;

  // Restoring division steps over quotient bits hi down to hi-cnt+1.
  function automatic rnd_t div_chunk(input rnd_t s, input int hi, input int cnt);
    rnd_t r;
    logic [16:0] t;
    logic [4:0] idx;
    r = s;
    for (int k = 0; k < 6; k++) begin
      if (k < cnt) begin
        idx = 5'(hi - k);
        t = {r.rem[15:0], r.dmag[idx]};
        if (t >= {1'b0, r.wmag}) begin
          r.rem = t - {1'b0, r.wmag};
          r.q[idx] = 1'b1;
        end else begin
          r.rem = t;
        end
      end
    end
    return r;
  endfunction

  always_comb begin
    logic [31:0] diff;
    logic [31:0] dvd;
    logic [15:0] qw;
    logic [15:0] ne;
    logic        ok;
    s1_next = '0;
    s1_next.it = i;
    s1_next.sq = 32'($signed(i.est) * $signed(i.est));

    s2_next = s1;
    diff = s1.sq - s1.it.value;
    dvd = {diff[31], diff[31:1]};
    s2_next.neg = dvd[31] ^ s1.it.est[15];
    s2_next.wmag = s1.it.est[15] ? 16'(-s1.it.est) : s1.it.est;
    s2_next.dmag = dvd[31] ? 32'(-dvd) : dvd;
    s2_next.rem = {2'b00, s2_next.dmag[31:17]};
    s2_next.q = '0;
    if (s1.it.live) begin
      if (s1.it.est == 16'd0 || (dvd == 32'h8000_0000 && s1.it.est == 16'hFFFF)) begin
        s2_next.it.live = 1'b0;
        s2_next.it.status = ST_INVALID;
        s2_next.it.est = '0;
      end else if ({1'b0, s2_next.dmag[31:17]} >= s2_next.wmag) begin
        s2_next.it.live = 1'b0;
        s2_next.it.status = ST_OVERFLOW;
        s2_next.it.est = '0;
      end
    end

    s3_next = div_chunk(s2, 16, 6);
    s4_next = div_chunk(s3, 10, 6);
    s5_next = div_chunk(s4, 4, 5);

    s6_next = s5.it;
    ok = s5.neg ? (s5.q <= 17'd32768) : (s5.q <= 17'd32767);
    qw = s5.neg ? 16'(-s5.q) : s5.q[15:0];
    ne = s5.it.est - qw;
    if (s5.it.live) begin
      if (!ok) begin
        s6_next.live = 1'b0;
        s6_next.status = ST_OVERFLOW;
        s6_next.est = '0;
      end else begin
        s6_next.est = (ne == 16'd0) ? 16'd1 : ne;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.it.valid <= 1'b0;
      s2.it.valid <= 1'b0;
      s3.it.valid <= 1'b0;
      s4.it.valid <= 1'b0;
      s5.it.valid <= 1'b0;
      s6.valid <= 1'b0;
    end else if (en) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s3_next;
      s4 <= s4_next;
      s5 <= s5_next;
      s6 <= s6_next;
    end
  end

  assign o = s6;

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    s6.valid && s6.status != ST_OK |-> s6.est == 16'd0)
    else $error("error word with nonzero estimate");
  a_live_ok: assert property (@(posedge clk) disable iff (rst)
    s6.valid && s6.live |-> s6.status == ST_OK && s6.est != 16'd0)
    else $error("live word lost its estimate");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    s3.it.valid && s3.it.live |-> s3.rem < {1'b0, s3.wmag})
    else $error("divider remainder out of range");

endmodule

### rtl/core/newton_integer_sqrt_core.sv
`timescale 1ns / 1ps
// Newton integer square root, fully pipelined.
// The src channel takes one 32-bit word per cycle (radicand); the res
// channel returns one word per input, in order, with a 16-bit root and a
// 2-bit status (ok, quotient overflow, invalid divide).
// An entry stage finds the highest set bit and forms the start estimate.
// Each Newton round is six register stages: a 16x16 square, dividend and
// operand preparation, three stages of restoring division (six, six and
// five quotient bits), and the estimate update. The entry register loads at
// the accepting edge and 3*6 = 18 round stages follow; res is driven from
// the final register of the last round.
// Throughput is one word per cycle; the divider stages set that figure,
// since each stage of the division holds a different word.
// Reset clears the valid bits of every stage; no word is in flight after it.
// When the receiver stalls, the whole pipeline holds and src.ready drops, so
// nothing is lost or repeated. While res is not stalled, src.ready stays high.
module newton_integer_sqrt_core
  import nisq_pkg::*;
(
  input logic clk,
  input logic rst,
  nisq_in_if.sink    src,
  nisq_out_if.source res
);

  logic  en;
  item_t e0, e0_next;
  item_t chain [NISQ_ROUNDS+1];

  assign en = !res.valid || res.ready;
  assign src.ready = en;

  // Entry stage: highest set bit and start estimate. A zero input finishes here.
  always_comb begin
    logic [4:0] h;
    h = '0;
    for (int b = 0; b < 32; b++) begin
      if (src.radicand[b]) h = 5'(b);
    end
    e0_next.valid = src.valid;
    e0_next.status = ST_OK;
    e0_next.value = src.radicand;
    if (src.radicand == 32'd0) begin
      e0_next.live = 1'b0;
      e0_next.est = '0;
    end else begin
      e0_next.live = 1'b1;
      e0_next.est = 16'd1 << h[4:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e0.valid <= 1'b0;
    end else if (en) begin
      e0 <= e0_next;
    end
  end

  assign chain[0] = e0;

  for (genvar g = 0; g < NISQ_ROUNDS; g++) begin : g_round
    nisq_round u_round (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .i   (chain[g]),
      .o   (chain[g+1])
    );
  end

  assign res.valid = chain[NISQ_ROUNDS].valid;
  assign res.root = chain[NISQ_ROUNDS].est;
  assign res.status = chain[NISQ_ROUNDS].status;

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |-> !src.ready)
    else $error("input taken while output stalled");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.status != 2'd3)
    else $error("undefined status code");
  a_err_root: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status != ST_OK |-> res.root == 16'd0)
    else $error("error word with nonzero root");

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import nisq_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #4 clk = ~clk;

  nisq_in_if  src ();
  nisq_out_if res ();

  newton_integer_sqrt_core uut (
    .clk(clk),
    .rst(rst),
    .src(src.sink),
    .res(res.source)
  );

  // One expected result word: the root and its status.
  typedef struct packed {
    logic [15:0] root;
    status_t     status;
  } root_word_t;

  root_word_t pending_roots[$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PIPE_LATENCY = 19;

  // Computes the root and status the block should give for one value. The
  // estimate is kept as a 16-bit word, and every round checks its divide
  // operands and the range of the quotient before it updates the estimate.
  function automatic root_word_t sqrt_predict(logic [31:0] value);
    root_word_t r;
    int hb;
    logic [15:0] est;
    logic signed [15:0] w;
    logic signed [31:0] sq;
    logic [31:0] diff;
    logic signed [31:0] dvd;
    logic signed [31:0] quo;
    r.root = '0;
    r.status = ST_OK;
    if (value == 32'd0) return r;
    hb = 0;
    for (int i = 0; i < 32; i++) if (value[i]) hb = i;
    est = 16'd1 << (hb / 2);
    for (int k = 0; k < NISQ_ROUNDS; k++) begin
      w = est;
      sq = w * w;
      diff = sq - value;
      dvd = $signed(diff) >>> 1;
      if (w == 0 || (dvd == 32'sh8000_0000 && w == -16'sd1)) begin
        r.status = ST_INVALID;
        return r;
      end
      quo = dvd / 32'(w);
      if (quo < -32768 || quo > 32767) begin
        r.status = ST_OVERFLOW;
        return r;
      end
      est = est - quo[15:0];
      if (est == 16'd0) est = 16'd1;
    end
    r.root = est;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  // Sends one word: waits a random gap, then holds valid until accepted.
  // Valid stays high after acceptance until the next falling edge decides.
  task automatic send_value(logic [31:0] value);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    @(negedge clk);
    if (gap > 0) begin
      src.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    src.valid <= 1'b1;
    src.radicand <= value;
    do @(posedge clk); while (!src.ready);
    pending_roots.push_back(sqrt_predict(value));
  endtask

  // The sink side stalls at random, with stretches of no stalling.
  int stall_left = 0;
  int calm_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (calm_left > 0) begin
      calm_left <= calm_left - 1;
      res.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
      if ($urandom_range(0, 15) == 0) calm_left <= $urandom_range(20, 60);
      else stall_left <= $urandom_range(0, 5);
    end
  end

  // Checks every accepted result against the oldest expectation.
  always @(posedge clk) begin
    root_word_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_roots.size() == 0) begin
        report("unexpected word", {res.status, res.root}, 32'd0);
      end else begin
        want = pending_roots.pop_front();
        if (res.root !== want.root) report("root", res.root, want.root);
        if (res.status !== want.status) report("status", res.status, want.status);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((src.valid && src.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired at %0t", $realtime);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Zero, both ends of the signed range, powers of two (including the ones
  // whose start estimate wraps to -32768), perfect squares and neighbors.
  task automatic test_directed();
    logic [31:0] vals[$];
    vals = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd15, 32'd16, 32'd17,
             32'd65535, 32'd65536, 32'd1000000, 32'h3FFF_FFFF, 32'h4000_0000,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF,
             32'hFFFE_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'd1073676289};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  // Random values with the highest set bit spread evenly over all indexes,
  // so small and large magnitudes both appear often.
  task automatic test_random(int count);
    logic [31:0] v;
    int hb;
    for (int n = 0; n < count; n++) begin
      hb = $urandom_range(0, 31);
      v = $urandom();
      v = (hb == 31) ? v : (v & ((32'd1 << (hb + 1)) - 1));
      v[hb] = 1'b1;
      if ($urandom_range(0, 50) == 0) v = 32'd0;
      send_value(v);
    end
  endtask

  // The sender holds off until the pipeline has fully drained.
  task automatic test_drain_pause();
    @(negedge clk);
    src.valid <= 1'b0;
    wait (pending_roots.size() == 0);
    repeat (PIPE_LATENCY) @(negedge clk);
  endtask

  initial begin
    src.valid = 1'b0;
    src.radicand = '0;
    res.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_drain_pause();
    test_random(600);
    test_drain_pause();
    test_random(580);
    @(negedge clk);
    src.valid <= 1'b0;
    wait (pending_roots.size() == 0);
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
